/* rtl/jkv_pkg.sv */
// Shared types and constants for the JSON key/value extractor.
// Used by jkv_parser and json_key_value_extractor; no dependencies.
`timescale 1ns / 1ps

package jkv_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int WIN           = MAX_KEY_BYTES + 2;
    localparam int KLEN_W        = 4;
    localparam int DATA_W        = 112;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_BYTES  = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_VALUE_KIND = 2'd2;
    localparam logic [1:0] CFG_CAPACITY   = 2'd3;

    // value kinds
    localparam logic [1:0] KIND_STRICT = 2'd0;
    localparam logic [1:0] KIND_TRUNC  = 2'd1;
    localparam logic [1:0] KIND_INT    = 2'd2;
    localparam logic [1:0] KIND_BOOL   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ABSENT  = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_ESCAPE  = 3'd3;
    localparam logic [2:0] ST_TOOLONG = 3'd4;
    localparam logic [2:0] ST_UNTERM  = 3'd5;

    // item kinds
    localparam logic ITEM_CHAR   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    typedef struct packed {
        logic               item_kind;
        logic [7:0]         char_value;
        logic [15:0]        char_position;
        logic [2:0]         status;
        logic signed [63:0] number_value;
        logic               truth_value;
        logic [15:0]        text_length;
        logic               overflowed;
    } result_t;

    // results caused by one accepted byte: an optional character, then an optional status
    typedef struct packed {
        logic    chr_vld;
        logic    stat_vld;
        result_t chr;
        result_t stat;
    } step_out_t;

    function automatic logic [DATA_W-1:0] pack_result(input result_t r);
        pack_result = {3'b000, r.overflowed, r.text_length, r.truth_value,
                       r.number_value, r.status, r.char_position, r.char_value};
    endfunction

endpackage

/* rtl/jkv_parser.sv */
// Key search, value parse and per-object state for the JSON extractor.
// Depends on jkv_pkg; one byte is consumed per accepted transaction.
`timescale 1ns / 1ps

module jkv_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output jkv_pkg::step_out_t     res
);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_COLON,
        PH_VALUE,
        PH_STR,
        PH_INT_FIRST,
        PH_INT,
        PH_LIT,
        PH_LIT_DONE,
        PH_DONE
    } phase_t;

    // configuration
    logic [63:0]                 key_reg;
    logic [jkv_pkg::KLEN_W-1:0]  klen_reg;
    logic [1:0]                  kind_reg;
    logic [15:0]                 cap_reg;

    // per-object state
    logic [7:0]  win_reg  [jkv_pkg::WIN];
    logic [7:0]  win_next [jkv_pkg::WIN];
    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [2:0]  lpos_reg, lpos_next;
    logic [2:0]  held_reg, held_next;
    logic        ovf_reg, ovf_next;
    logic        ltrue_reg, ltrue_next;

    logic [7:0]                   b;
    logic                         b_ws, b_delim, b_digit;
    logic [jkv_pkg::KLEN_W-1:0]   kl;
    logic                         hit [jkv_pkg::MAX_KEY_BYTES+1];
    logic                         key_hit;
    logic [67:0]                  acc_x10;
    logic [2:0]                   lit_len;
    logic [7:0]                   lit_char;
    logic [16:0]                  cnt_inc;
    logic [2:0]                   fin_st;

    function automatic logic [7:0] word_char(input logic is_true, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (is_true) begin
            case (pos[1:0])
                2'd0:    c = "t";
                2'd1:    c = "r";
                2'd2:    c = "u";
                default: c = "e";
            endcase
        end
        else begin
            case (pos)
                3'd0:    c = "f";
                3'd1:    c = "a";
                3'd2:    c = "l";
                3'd3:    c = "s";
                3'd4:    c = "e";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    assign b       = in_byte;
    assign b_ws    = (b == jkv_pkg::CH_SPACE) || (b == jkv_pkg::CH_TAB) ||
                     (b == jkv_pkg::CH_CR) || (b == jkv_pkg::CH_LF);
    assign b_delim = b_ws || (b == jkv_pkg::CH_COMMA) || (b == jkv_pkg::CH_RBRACE);
    assign b_digit = (b >= jkv_pkg::CH_ZERO) && (b <= jkv_pkg::CH_NINE);
    assign kl      = (klen_reg > jkv_pkg::KLEN_W'(jkv_pkg::MAX_KEY_BYTES)) ?
                     jkv_pkg::KLEN_W'(jkv_pkg::MAX_KEY_BYTES) : klen_reg;
    // acc * 10 + digit, four guard bits catch magnitude overflow
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, b[3:0]};
    assign lit_len = ltrue_reg ? 3'd4 : 3'd5;
    assign lit_char = word_char(ltrue_reg, lpos_reg);
    assign cnt_inc = {1'b0, cnt_reg} + 17'd1;

    // shifted window and key compare at every key length
    always_comb
    begin
        for (int j = 0; j < jkv_pkg::WIN - 1; j++)
        begin
            win_next[j] = win_reg[j+1];
        end
        win_next[jkv_pkg::WIN-1] = b;
        for (int k = 0; k <= jkv_pkg::MAX_KEY_BYTES; k++)
        begin
            hit[k] = (win_next[jkv_pkg::WIN-1] == jkv_pkg::CH_QUOTE) &&
                     (win_next[jkv_pkg::WIN-2-k] == jkv_pkg::CH_QUOTE);
            for (int i = 0; i < k; i++)
            begin
                if (win_next[jkv_pkg::WIN-1-k+i] != key_reg[8*i +: 8])
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    assign key_hit = hit[kl];

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        lpos_next  = lpos_reg;
        held_next  = held_reg;
        ovf_next   = ovf_reg;
        ltrue_next = ltrue_reg;
        res        = '0;
        fin_st     = jkv_pkg::ST_OK;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (key_hit)
                begin
                    phase_next = PH_COLON;
                end
            end
            PH_COLON:
            begin
                if (b == jkv_pkg::CH_COLON)
                begin
                    phase_next = PH_VALUE;
                end
                else if (!b_ws)
                begin
                    phase_next = key_hit ? PH_COLON : PH_SEARCH;
                end
            end
            PH_VALUE:
            begin
                if (!b_ws)
                begin
                    case (kind_reg) inside
                        jkv_pkg::KIND_STRICT, jkv_pkg::KIND_TRUNC:
                        begin
                            if (b != jkv_pkg::CH_QUOTE || cap_reg == 16'd0)
                            begin
                                held_next  = jkv_pkg::ST_BAD;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_STR;
                            end
                        end
                        jkv_pkg::KIND_INT:
                        begin
                            if (b == jkv_pkg::CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                phase_next = PH_INT_FIRST;
                            end
                            else if (b_digit)
                            begin
                                acc_next   = {60'd0, b[3:0]};
                                phase_next = PH_INT;
                            end
                            else
                            begin
                                held_next  = jkv_pkg::ST_BAD;
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            if (b == jkv_pkg::CH_T || b == jkv_pkg::CH_F)
                            begin
                                ltrue_next = (b == jkv_pkg::CH_T);
                                lpos_next  = 3'd1;
                                phase_next = PH_LIT;
                            end
                            else
                            begin
                                held_next  = jkv_pkg::ST_BAD;
                                phase_next = PH_DONE;
                            end
                        end
                    endcase
                end
            end
            PH_STR:
            begin
                if (b == jkv_pkg::CH_QUOTE)
                begin
                    held_next  = jkv_pkg::ST_OK;
                    phase_next = PH_DONE;
                end
                else if (b == jkv_pkg::CH_BSLASH)
                begin
                    held_next  = jkv_pkg::ST_ESCAPE;
                    phase_next = PH_DONE;
                end
                else if (cnt_inc >= {1'b0, cap_reg})
                begin
                    // buffer full: truncating mode drops the character
                    if (kind_reg != jkv_pkg::KIND_TRUNC)
                    begin
                        held_next  = jkv_pkg::ST_TOOLONG;
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    res.chr_vld           = 1'b1;
                    res.chr.item_kind     = jkv_pkg::ITEM_CHAR;
                    res.chr.char_value    = b;
                    res.chr.char_position = cnt_reg;
                    cnt_next              = cnt_inc[15:0];
                end
            end
            PH_INT_FIRST, PH_INT:
            begin
                if (b_digit)
                begin
                    acc_next   = acc_x10[63:0];
                    ovf_next   = ovf_reg | (acc_x10[67:64] != 4'd0);
                    phase_next = PH_INT;
                end
                else
                begin
                    held_next  = (phase_reg == PH_INT && b_delim) ? jkv_pkg::ST_OK :
                                                                   jkv_pkg::ST_BAD;
                    phase_next = PH_DONE;
                end
            end
            PH_LIT:
            begin
                if (lpos_reg < lit_len && b == lit_char)
                begin
                    lpos_next = lpos_reg + 3'd1;
                    if (lpos_next >= lit_len)
                    begin
                        phase_next = PH_LIT_DONE;
                    end
                end
                else
                begin
                    held_next  = jkv_pkg::ST_BAD;
                    phase_next = PH_DONE;
                end
            end
            PH_LIT_DONE:
            begin
                held_next  = b_delim ? jkv_pkg::ST_OK : jkv_pkg::ST_BAD;
                phase_next = PH_DONE;
            end
            default:
            begin
            end
        endcase

        if (in_last)
        begin
            case (phase_next) inside
                PH_SEARCH, PH_COLON, PH_VALUE: fin_st = jkv_pkg::ST_ABSENT;
                PH_STR:                        fin_st = jkv_pkg::ST_UNTERM;
                PH_INT_FIRST, PH_LIT:          fin_st = jkv_pkg::ST_BAD;
                PH_INT, PH_LIT_DONE:           fin_st = jkv_pkg::ST_OK;
                default:                       fin_st = held_next;
            endcase
            res.stat_vld       = 1'b1;
            res.stat.item_kind = jkv_pkg::ITEM_STATUS;
            res.stat.status    = fin_st;
            if (kind_reg == jkv_pkg::KIND_INT && fin_st == jkv_pkg::ST_OK)
            begin
                res.stat.number_value = neg_next ? (64'sd0 - $signed(acc_next)) :
                                                   $signed(acc_next);
                res.stat.overflowed   = ovf_next;
            end
            if (kind_reg == jkv_pkg::KIND_BOOL && fin_st == jkv_pkg::ST_OK)
            begin
                res.stat.truth_value = ltrue_next;
            end
            if (kind_reg == jkv_pkg::KIND_STRICT || kind_reg == jkv_pkg::KIND_TRUNC)
            begin
                res.stat.text_length = cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            klen_reg <= '0;
            kind_reg <= jkv_pkg::KIND_STRICT;
            cap_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jkv_pkg::CFG_KEY_BYTES:  key_reg  <= cfg_data;
                jkv_pkg::CFG_KEY_LENGTH: klen_reg <= cfg_data[jkv_pkg::KLEN_W-1:0];
                jkv_pkg::CFG_VALUE_KIND: kind_reg <= cfg_data[1:0];
                jkv_pkg::CFG_CAPACITY:   cap_reg  <= cfg_data[15:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < jkv_pkg::WIN; j++)
            begin
                win_reg[j] <= 8'h00;
            end
            phase_reg <= PH_SEARCH;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            lpos_reg  <= '0;
            held_reg  <= jkv_pkg::ST_OK;
            ovf_reg   <= 1'b0;
            ltrue_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            if (in_last)
            begin
                // object done: drop all per-object state
                for (int j = 0; j < jkv_pkg::WIN; j++)
                begin
                    win_reg[j] <= 8'h00;
                end
                phase_reg <= PH_SEARCH;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                lpos_reg  <= '0;
                held_reg  <= jkv_pkg::ST_OK;
                ovf_reg   <= 1'b0;
                ltrue_reg <= 1'b0;
            end
            else
            begin
                for (int j = 0; j < jkv_pkg::WIN; j++)
                begin
                    win_reg[j] <= win_next[j];
                end
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                lpos_reg  <= lpos_next;
                held_reg  <= held_next;
                ovf_reg   <= ovf_next;
                ltrue_reg <= ltrue_next;
            end
        end
    end

endmodule

/* rtl/json_key_value_extractor.sv */
// A byte's results are written into the output queue at its accepting edge. Throughput:
// one byte per cycle while s_tready is high; a byte with two results (last string
// character plus status) fills two queue entries, and s_tready drops while the 4-entry
// output queue has fewer than two free slots. Reset: configuration to its reset values,
// parser state cleared, queue empty; no clearing pass, ready right after reset.
// Top level: stream ports, jkv_parser and the output queue; depends on jkv_pkg.
`timescale 1ns / 1ps

module json_key_value_extractor
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [63:0]                 cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // text_byte
    input  logic                        s_tlast,   // object_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // char_value, char_position, status, number_value, truth_value, text_length,
    // overflowed, zero pad
    output logic [jkv_pkg::DATA_W-1:0]  m_tdata,
    output logic [0:0]                  m_tuser    // item_kind
);

    jkv_pkg::step_out_t               step;
    logic                             accept;
    logic                             push0, push1, pop;
    jkv_pkg::result_t                 entry0;
    jkv_pkg::result_t                 q_mem [jkv_pkg::QDEPTH];
    logic [jkv_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [jkv_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [jkv_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    jkv_pkg::result_t                 head;

    assign accept = s_tvalid && s_tready;

    jkv_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res       (step)
    );

    assign push0  = accept && (step.chr_vld || step.stat_vld);
    assign push1  = accept && step.chr_vld && step.stat_vld;
    assign entry0 = step.chr_vld ? step.chr : step.stat;
    assign pop    = m_tvalid && m_tready;

    assign s_tready = (cnt_reg <= jkv_pkg::QCNT_W'(jkv_pkg::QDEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign head     = q_mem[rd_ptr_reg];
    assign m_tdata  = jkv_pkg::pack_result(head);
    assign m_tuser  = head.item_kind;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + jkv_pkg::QPTR_W'(push0) + jkv_pkg::QPTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + jkv_pkg::QPTR_W'(pop);
        cnt_next    = cnt_reg + jkv_pkg::QCNT_W'(push0) + jkv_pkg::QCNT_W'(push1)
                      - jkv_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            q_mem[wr_ptr_reg] <= entry0;
        end
        if (push1)
        begin
            q_mem[wr_ptr_reg + jkv_pkg::QPTR_W'(1)] <= step.stat;
        end
    end

endmodule
